### design/dlo_pkg.sv
// ----------------------------------------------------------------------------
// dlo_pkg
// Shared widths, constants, codes and stage bus types of the local offset unit.
// ----------------------------------------------------------------------------
package dlo_pkg;

  localparam int IN_W    = 34;
  localparam int HI_W    = IN_W - 7;
  localparam int DAY_W   = 18;
  localparam int SOD_W   = 17;
  localparam int DOY_W   = 9;
  localparam int YOFF_W  = 10;
  localparam int YEAR_W  = 12;
  localparam int Q100_W  = 5;
  localparam int SEC_W   = 25;
  localparam int LHS_W   = 27;
  localparam int OFF_W   = 11;
  localparam int RULE_W  = 2;
  localparam int SDAY_W  = 9;

  localparam int          RECIP_W     = 18;
  localparam logic [17:0] RECIP_675   = 18'd198841;
  localparam int          RECIP_SHIFT = 27;
  localparam logic [19:0] RECIP_YEAR  = 20'd734951;
  localparam int          YEAR_SHIFT  = 28;
  localparam logic [12:0] RECIP_100   = 13'd5243;
  localparam int          R100_SHIFT  = 19;

  localparam logic [RULE_W-1:0] RULE_NONE = 2'd0;
  localparam logic [RULE_W-1:0] RULE_US   = 2'd1;
  localparam logic [RULE_W-1:0] RULE_EU   = 2'd2;

  localparam logic REG_STD_OFFSET = 1'b0;
  localparam logic REG_DST_RULE   = 1'b1;

  typedef struct packed {
    logic [DAY_W-1:0] day;
    logic [SOD_W-1:0] sod;
  } day_sod_t;

  typedef struct packed {
    logic [DAY_W-1:0] jan1;
    logic             leap;
    logic [DOY_W-1:0] doy;
    logic [SOD_W-1:0] sod;
  } year_info_t;

endpackage

### design/dst_local_offset_unit.sv
// ----------------------------------------------------------------------------
// dst_local_offset_unit
// Local UTC offset and daylight flag under a US/Canada or EU daylight rule.
// A request passes the input register, day split, year search and rule evaluation.
// Throughput: one request per cycle.
// busy is never raised; the receiver cannot stall and none is needed.
// Reset clears the pipe valid bits and both registers (offset 0, no rule).
// ----------------------------------------------------------------------------
module dst_local_offset_unit #(
  parameter int TIME_BITS = 34
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic [dlo_pkg::IN_W-1:0]         utc_seconds_i,
  output logic                             result_valid_o,
  output logic signed [dlo_pkg::OFF_W-1:0] offset_minutes_o,
  output logic                             daylight_active_o,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [dlo_pkg::OFF_W-1:0]        cfg_wdata_i
);
  import dlo_pkg::*;

  localparam int TW = (TIME_BITS < IN_W) ? TIME_BITS : IN_W;
  localparam logic [IN_W-1:0] TIME_MASK = {IN_W{1'b1}} >> (IN_W - TW);

  logic signed [OFF_W-1:0] std_off_q;
  logic [RULE_W-1:0]       rule_q;
  logic                    in_valid_q;
  logic [IN_W-1:0]         in_time_q;

  logic                    day_valid;
  day_sod_t                day_bus;
  logic                    year_valid;
  year_info_t              year_bus;

  assign busy = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      std_off_q  <= '0;
      rule_q     <= RULE_NONE;
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= start && !busy;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STD_OFFSET: std_off_q <= cfg_wdata_i;
          REG_DST_RULE:   rule_q    <= cfg_wdata_i[RULE_W-1:0];
          default:        rule_q    <= rule_q;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    in_time_q <= utc_seconds_i & TIME_MASK;
  end

  dlo_day_split u_day_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .time_i  (in_time_q),
    .valid_o (day_valid),
    .day_o   (day_bus)
  );

  dlo_year_find u_year_find (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (day_valid),
    .day_i   (day_bus),
    .valid_o (year_valid),
    .info_o  (year_bus)
  );

  dlo_rule_eval u_rule_eval (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .valid_i           (year_valid),
    .info_i            (year_bus),
    .std_off_i         (std_off_q),
    .rule_i            (rule_q),
    .valid_o           (result_valid_o),
    .offset_minutes_o  (offset_minutes_o),
    .daylight_active_o (daylight_active_o)
  );

endmodule

### design/dlo_day_split.sv
// ----------------------------------------------------------------------------
// dlo_day_split
// Two-stage split of a UTC second count into day number and second of day.
// ----------------------------------------------------------------------------
module dlo_day_split (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [dlo_pkg::IN_W-1:0] time_i,
  output logic                    valid_o,
  output dlo_pkg::day_sod_t       day_o
);
  import dlo_pkg::*;

  logic [HI_W+RECIP_W-1:0] prod1;
  logic               s1_valid_q;
  logic [DAY_W-1:0]   s1_quot_q;
  logic [HI_W-1:0]    s1_hi_q;
  logic [6:0]         s1_lo_q;

  logic [DAY_W+10-1:0] prod2;
  logic [HI_W-1:0]     rem0;
  logic                over;
  logic [9:0]          rem;
  day_sod_t            day_d;
  day_sod_t            day_q;
  logic                s2_valid_q;

  assign prod1 = time_i[IN_W-1:7] * RECIP_675;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_quot_q <= prod1[RECIP_SHIFT +: DAY_W];
    s1_hi_q   <= time_i[IN_W-1:7];
    s1_lo_q   <= time_i[6:0];
    day_q     <= day_d;
  end

  always_comb begin
    prod2 = s1_quot_q * 10'd675;
    rem0  = s1_hi_q - prod2[HI_W-1:0];
    over  = (rem0 >= HI_W'(675));
    if (over) begin
      day_d.day = s1_quot_q + DAY_W'(1);
      rem       = 10'(rem0 - HI_W'(675));
    end else begin
      day_d.day = s1_quot_q;
      rem       = rem0[9:0];
    end
    day_d.sod = {rem, s1_lo_q};
  end

  assign valid_o = s2_valid_q;
  assign day_o   = day_q;

endmodule

### design/dlo_year_find.sv
// ----------------------------------------------------------------------------
// dlo_year_find
// Four-stage search for the calendar year, its January 1 and leap flag.
// ----------------------------------------------------------------------------
module dlo_year_find (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  dlo_pkg::day_sod_t    day_i,
  output logic                 valid_o,
  output dlo_pkg::year_info_t  info_o
);
  import dlo_pkg::*;

  logic [DAY_W-1:0]        dm2;
  logic [DAY_W+20-1:0]     prod3;
  logic                    s3_valid_q;
  logic [YOFF_W-1:0]       s3_est_q;
  day_sod_t                s3_day_q;

  logic [YEAR_W-1:0]       n;
  logic [YEAR_W+13-1:0]    prod4;
  logic                    s4_valid_q;
  logic [YEAR_W-1:0]       s4_n_q;
  logic [Q100_W-1:0]       s4_q100_q;
  logic [YOFF_W-1:0]       s4_est_q;
  day_sod_t                s4_day_q;

  logic [YEAR_W-1:0]       r100;
  logic [YEAR_W-1:0]       lcount;
  logic [YOFF_W+9-1:0]     base;
  logic [Q100_W-1:0]       q1;
  logic                    leap0;
  logic                    leap1;
  logic                    s5_valid_q;
  logic [DAY_W-1:0]        s5_jan1_q;
  logic                    s5_leap0_q;
  logic                    s5_leap1_q;
  day_sod_t                s5_day_q;

  logic [DAY_W-1:0]        nxt;
  logic                    sel;
  year_info_t              info_d;
  year_info_t              info_q;
  logic                    s6_valid_q;

  always_comb begin
    dm2   = (day_i.day >= DAY_W'(2)) ? day_i.day - DAY_W'(2) : '0;
    prod3 = dm2 * RECIP_YEAR;
  end

  always_comb begin
    n     = YEAR_W'(s3_est_q) + YEAR_W'(1969);
    prod4 = n * RECIP_100;
  end

  always_comb begin
    r100   = s4_n_q - YEAR_W'(s4_q100_q) * YEAR_W'(100);
    lcount = YEAR_W'(s4_n_q[YEAR_W-1:2]) - YEAR_W'(s4_q100_q)
             + YEAR_W'(s4_q100_q[Q100_W-1:2]) - YEAR_W'(477);
    base   = s4_est_q * 9'd365;
    q1     = s4_q100_q + Q100_W'(1);
    leap0  = (s4_n_q[1:0] == 2'd3) && ((r100 != YEAR_W'(99)) || (q1[1:0] == 2'd0));
    leap1  = (s4_n_q[1:0] == 2'd2) && ((r100 != YEAR_W'(98)) || (q1[1:0] == 2'd0));
  end

  always_comb begin
    nxt = s5_jan1_q + DAY_W'(365) + DAY_W'(s5_leap0_q);
    sel = (s5_day_q.day >= nxt);
    info_d.jan1 = sel ? nxt : s5_jan1_q;
    info_d.leap = sel ? s5_leap1_q : s5_leap0_q;
    info_d.doy  = DOY_W'(s5_day_q.day - info_d.jan1);
    info_d.sod  = s5_day_q.sod;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= valid_i;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_est_q   <= prod3[YEAR_SHIFT +: YOFF_W];
    s3_day_q   <= day_i;
    s4_n_q     <= n;
    s4_q100_q  <= prod4[R100_SHIFT +: Q100_W];
    s4_est_q   <= s3_est_q;
    s4_day_q   <= s3_day_q;
    s5_jan1_q  <= DAY_W'(base) + DAY_W'(lcount);
    s5_leap0_q <= leap0;
    s5_leap1_q <= leap1;
    s5_day_q   <= s4_day_q;
    info_q     <= info_d;
  end

  assign valid_o = s6_valid_q;
  assign info_o  = info_q;

endmodule

### design/dlo_rule_eval.sv
// ----------------------------------------------------------------------------
// dlo_rule_eval
// Four-stage evaluation of the daylight window and the resulting offset.
// ----------------------------------------------------------------------------
module dlo_rule_eval (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             valid_i,
  input  dlo_pkg::year_info_t              info_i,
  input  logic signed [dlo_pkg::OFF_W-1:0] std_off_i,
  input  logic [dlo_pkg::RULE_W-1:0]       rule_i,
  output logic                             valid_o,
  output logic signed [dlo_pkg::OFF_W-1:0] offset_minutes_o,
  output logic                             daylight_active_o
);
  import dlo_pkg::*;

  function automatic logic [2:0] mod7_day(input logic [DAY_W-1:0] v);
    logic [5:0] s;
    logic [3:0] f;
    s = 6'(v[2:0]) + 6'(v[5:3]) + 6'(v[8:6]) + 6'(v[11:9]) + 6'(v[14:12])
        + 6'(v[17:15]);
    f = 4'(s[5:3]) + 4'(s[2:0]);
    return (f >= 4'd7) ? 3'(f - 4'd7) : f[2:0];
  endfunction

  function automatic logic [2:0] mod7_small(input logic [3:0] v);
    return (v >= 4'd7) ? 3'(v - 4'd7) : v[2:0];
  endfunction

  logic                    s7_valid_q;
  logic [2:0]              s7_wday_q;
  logic [SEC_W-1:0]        s7_now_q;
  logic                    s7_leap_q;
  logic [DOY_W+17-1:0]     now_prod;

  logic [2:0]              wd_a;
  logic [2:0]              wd_c;
  logic [2:0]              wd_d;
  logic [SDAY_W-1:0]       adv;
  logic [SDAY_W-1:0]       lp;
  logic [SDAY_W-1:0]       ds;
  logic [SDAY_W-1:0]       de;
  logic                    en;
  logic                    us;
  logic signed [LHS_W-1:0] off_ext;
  logic signed [LHS_W-1:0] off60;
  logic signed [LHS_W-1:0] lhs;
  logic                    s8_valid_q;
  logic [SDAY_W-1:0]       s8_ds_q;
  logic [SDAY_W-1:0]       s8_de_q;
  logic                    s8_en_q;
  logic                    s8_us_q;
  logic signed [LHS_W-1:0] s8_lhs_q;

  logic [SDAY_W+17-1:0]    start_prod;
  logic [SDAY_W+17-1:0]    stop_prod;
  logic                    s9_valid_q;
  logic [SEC_W-1:0]        s9_start_q;
  logic [SEC_W-1:0]        s9_stop_q;
  logic                    s9_en_q;
  logic signed [LHS_W-1:0] s9_lhs_q;

  logic                    dst;
  logic signed [OFF_W:0]   sum;
  logic signed [OFF_W-1:0] off_d;
  logic signed [OFF_W-1:0] off_q;
  logic                    dst_q;
  logic                    s10_valid_q;

  assign now_prod = info_i.doy * 17'd86400;

  always_comb begin
    lp   = SDAY_W'(s7_leap_q);
    wd_a = mod7_small(4'(s7_wday_q) + 4'd3 + 4'(s7_leap_q));
    wd_c = mod7_small(4'(s7_wday_q) + 4'd5 + 4'(s7_leap_q));
    wd_d = mod7_small(4'(s7_wday_q) + 4'd2 + 4'(s7_leap_q));
    adv  = (wd_a == 3'd0) ? '0 : SDAY_W'(3'd7 - wd_a);
    case (rule_i)
      RULE_US: begin
        ds = SDAY_W'(66) + lp + adv;
        de = SDAY_W'(304) + lp + adv;
        en = 1'b1;
        us = 1'b1;
      end
      RULE_EU: begin
        ds = SDAY_W'(89) + lp - SDAY_W'(wd_c);
        de = SDAY_W'(303) + lp - SDAY_W'(wd_d);
        en = 1'b1;
        us = 1'b0;
      end
      default: begin
        ds = '0;
        de = '0;
        en = 1'b0;
        us = 1'b0;
      end
    endcase
    off_ext = LHS_W'(std_off_i);
    off60   = (off_ext <<< 6) - (off_ext <<< 2);
    lhs     = $signed({{(LHS_W-SEC_W){1'b0}}, s7_now_q}) + (us ? off60 : '0);
  end

  always_comb begin
    start_prod = s8_ds_q * 17'd86400;
    stop_prod  = s8_de_q * 17'd86400;
  end

  always_comb begin
    dst = s9_en_q
          && (s9_lhs_q >= $signed({{(LHS_W-SEC_W){1'b0}}, s9_start_q}))
          && (s9_lhs_q <  $signed({{(LHS_W-SEC_W){1'b0}}, s9_stop_q}));
    sum = (OFF_W+1)'(std_off_i) + (dst ? (OFF_W+1)'(60) : '0);
    if (sum > (OFF_W+1)'(1023)) begin
      off_d = OFF_W'(1023);
    end else begin
      off_d = sum[OFF_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_valid_q  <= 1'b0;
      s8_valid_q  <= 1'b0;
      s9_valid_q  <= 1'b0;
      s10_valid_q <= 1'b0;
    end else begin
      s7_valid_q  <= valid_i;
      s8_valid_q  <= s7_valid_q;
      s9_valid_q  <= s8_valid_q;
      s10_valid_q <= s9_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s7_wday_q  <= mod7_day(info_i.jan1 + DAY_W'(4));
    s7_now_q   <= SEC_W'(now_prod) + SEC_W'(info_i.sod);
    s7_leap_q  <= info_i.leap;
    s8_ds_q    <= ds;
    s8_de_q    <= de;
    s8_en_q    <= en;
    s8_us_q    <= us;
    s8_lhs_q   <= lhs;
    s9_start_q <= SEC_W'(start_prod) + (s8_us_q ? SEC_W'(7200) : SEC_W'(3600));
    s9_stop_q  <= SEC_W'(stop_prod) + SEC_W'(3600);
    s9_en_q    <= s8_en_q;
    s9_lhs_q   <= s8_lhs_q;
    off_q      <= off_d;
    dst_q      <= dst;
  end

  assign valid_o           = s10_valid_q;
  assign offset_minutes_o  = off_q;
  assign daylight_active_o = dst_q;

endmodule

### tb/sv/dst_local_offset_unit_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_local_offset_unit_checker
// Watches the request and result channels of the local offset unit, predicts
// the offset and daylight flag of every accepted request from a calendar
// model of the US/Canada and EU rules, and compares each result strobe with
// the oldest prediction still outstanding.
// ----------------------------------------------------------------------------
module dst_local_offset_unit_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             busy_i,
  input  logic [dlo_pkg::IN_W-1:0]         utc_seconds_i,
  input  logic                             result_valid_i,
  input  logic signed [dlo_pkg::OFF_W-1:0] offset_minutes_i,
  input  logic                             daylight_active_i,
  input  logic                             cfg_we_i,
  input  logic                             cfg_idx_i,
  input  logic [dlo_pkg::OFF_W-1:0]        cfg_wdata_i,
  output int                               pending_o,
  output int                               fail_count_o
);
  import dlo_pkg::*;

  localparam longint unsigned DAY_SECONDS = 86400;
  localparam int              OFFSET_MAX  = 1023;
  localparam int              MARCH       = 2;
  localparam int              OCTOBER     = 9;
  localparam int              NOVEMBER    = 10;

  typedef struct packed {
    logic signed [OFF_W-1:0] offset_minutes;
    logic                    daylight_active;
  } local_offset_t;

  logic signed [OFF_W-1:0] std_offset = '0;
  logic [RULE_W-1:0]       dst_rule   = RULE_NONE;
  local_offset_t           pending_offsets[$];
  int                      errors     = 0;

  assign fail_count_o = errors;

  function automatic bit is_leap(longint unsigned y);
    return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
  endfunction

  function automatic longint unsigned year_of(longint unsigned day);
    longint unsigned z, era, doe, yoe, doy, mp, y;
    z   = day + 719468;
    era = z / 146097;
    doe = z - era * 146097;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp  = (5 * doy + 2) / 153;
    y   = yoe + era * 400;
    if (mp >= 10) begin
      y++;
    end
    return y;
  endfunction

  function automatic longint unsigned first_day_of(longint unsigned y);
    longint unsigned p, era, yoe, doe;
    p   = y - 1;
    era = p / 400;
    yoe = p - era * 400;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + 306;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic longint unsigned month_begin(longint unsigned y, int m0);
    longint unsigned b;
    case (m0)
      MARCH:    b = 59;
      OCTOBER:  b = 273;
      NOVEMBER: b = 304;
      default:  b = 0;
    endcase
    if (m0 > 1 && is_leap(y)) begin
      b++;
    end
    return b;
  endfunction

  function automatic longint unsigned weekday(longint unsigned jan1, longint unsigned doy);
    return (jan1 + doy + 4) % 7;
  endfunction

  function automatic local_offset_t predict_local_offset(logic [IN_W-1:0] utc);
    longint unsigned t, y, j1, sun_a, sun_b;
    longint          now, from, upto;
    bit              dst;
    int              off;
    local_offset_t   r;
    t   = utc;
    y   = year_of(t / DAY_SECONDS);
    j1  = first_day_of(y);
    now = longint'(t - j1 * DAY_SECONDS);
    dst = 1'b0;
    case (dst_rule)
      RULE_US: begin
        sun_a = month_begin(y, MARCH);
        sun_a += (7 - weekday(j1, sun_a)) % 7 + 7;
        sun_b = month_begin(y, NOVEMBER);
        sun_b += (7 - weekday(j1, sun_b)) % 7;
        from = longint'(sun_a) * 86400 + 7200 - longint'(std_offset) * 60;
        upto = longint'(sun_b) * 86400 + 7200 - (longint'(std_offset) + 60) * 60;
        dst  = now >= from && now < upto;
      end
      RULE_EU: begin
        sun_a = month_begin(y, MARCH) + 30;
        sun_a -= weekday(j1, sun_a);
        sun_b = month_begin(y, OCTOBER) + 30;
        sun_b -= weekday(j1, sun_b);
        from = longint'(sun_a) * 86400 + 3600;
        upto = longint'(sun_b) * 86400 + 3600;
        dst  = now >= from && now < upto;
      end
      default: dst = 1'b0;
    endcase
    off = int'(std_offset) + (dst ? 60 : 0);
    if (off > OFFSET_MAX) begin
      off = OFFSET_MAX;
    end
    r.offset_minutes  = off[OFF_W-1:0];
    r.daylight_active = dst;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    local_offset_t want;
    if (!rst_ni) begin
      std_offset = '0;
      dst_rule   = RULE_NONE;
      pending_offsets.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_STD_OFFSET) begin
          std_offset = cfg_wdata_i;
        end else begin
          dst_rule = cfg_wdata_i[RULE_W-1:0];
        end
      end
      if (start_i && !busy_i) begin
        pending_offsets.push_back(predict_local_offset(utc_seconds_i));
      end
      if (result_valid_i) begin
        if (pending_offsets.size() == 0) begin
          errors++;
          $error("result strobe with no request outstanding");
        end else begin
          want = pending_offsets.pop_front();
          if (offset_minutes_i !== want.offset_minutes) begin
            errors++;
            $error("offset_minutes: expected %0d, got %0d",
                   $signed(want.offset_minutes), $signed(offset_minutes_i));
          end
          if (daylight_active_i !== want.daylight_active) begin
            errors++;
            $error("daylight_active: expected %0b, got %0b",
                   want.daylight_active, daylight_active_i);
          end
        end
      end
      pending_o <= pending_offsets.size();
    end
  end

endmodule

### tb/sv/dst_local_offset_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dst_local_offset_unit_tb
// Drives UTC timestamps into the local offset unit under a series of zone
// offsets and daylight rules: a directed set around the spring and fall
// transitions, leap days, year boundaries and the ends of the time range,
// then random timestamps clustered near transition instants, with random
// gaps between requests. The checker beside the unit scores every result.
// ----------------------------------------------------------------------------
module dst_local_offset_unit_tb;
  import dlo_pkg::*;

  typedef enum int {US_SPRING, US_FALL, EU_SPRING, EU_FALL} shift_e;

  localparam logic [RULE_W-1:0] RULE_UNUSED  = 2'd3;
  localparam longint            DAY_SECONDS  = 86400;
  localparam longint            TIME_LIMIT   = (longint'(1) << IN_W) - 1;
  localparam int                FIRST_YEAR   = 1970;
  localparam int                LAST_YEAR    = 2513;
  localparam int                DRAIN_CYCLES = 20;
  localparam int                PHASES       = 12;
  localparam int                PHASE_ITEMS  = 44;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    start         = 1'b0;
  logic                    busy;
  logic [IN_W-1:0]         utc_seconds_i = '0;
  logic                    result_valid_o;
  logic signed [OFF_W-1:0] offset_minutes_o;
  logic                    daylight_active_o;
  logic                    cfg_we_i      = 1'b0;
  logic                    cfg_idx_i     = REG_STD_OFFSET;
  logic [OFF_W-1:0]        cfg_wdata_i   = '0;
  int                      pending;
  int                      fail_count;
  logic signed [OFF_W-1:0] zone_offset   = '0;

  always #5 clk_i = ~clk_i;

  dst_local_offset_unit dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .utc_seconds_i     (utc_seconds_i),
    .result_valid_o    (result_valid_o),
    .offset_minutes_o  (offset_minutes_o),
    .daylight_active_o (daylight_active_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  dst_local_offset_unit_checker u_offset_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start),
    .busy_i            (busy),
    .utc_seconds_i     (utc_seconds_i),
    .result_valid_i    (result_valid_o),
    .offset_minutes_i  (offset_minutes_o),
    .daylight_active_i (daylight_active_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .pending_o         (pending),
    .fail_count_o      (fail_count)
  );

  function automatic longint civil_day(longint y, int m, int d);
    longint era, yoe, doe;
    int     doy;
    if (m <= 2) begin
      y--;
    end
    era = y / 400;
    yoe = y - era * 400;
    doy = (153 * (m > 2 ? m - 3 : m + 9) + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic longint shift_instant(longint y, shift_e kind);
    longint d, t;
    case (kind)
      US_SPRING: begin
        d = civil_day(y, 3, 1);
        d += (7 - (d + 4) % 7) % 7 + 7;
        t = d * DAY_SECONDS + 7200 - longint'(zone_offset) * 60;
      end
      US_FALL: begin
        d = civil_day(y, 11, 1);
        d += (7 - (d + 4) % 7) % 7;
        t = d * DAY_SECONDS + 7200 - (longint'(zone_offset) + 60) * 60;
      end
      EU_SPRING: begin
        d = civil_day(y, 3, 31);
        d -= (d + 4) % 7;
        t = d * DAY_SECONDS + 3600;
      end
      default: begin
        d = civil_day(y, 10, 31);
        d -= (d + 4) % 7;
        t = d * DAY_SECONDS + 3600;
      end
    endcase
    return t;
  endfunction

  function automatic logic [IN_W-1:0] pick_utc();
    longint t, y;
    int     r;
    r = $urandom_range(99);
    y = longint'(($urandom_range(3) != 0) ? $urandom_range(2100, FIRST_YEAR)
                                          : $urandom_range(LAST_YEAR, FIRST_YEAR));
    if (r < 25) begin
      t = {$urandom_range(3), $urandom()};
    end else begin
      if (r < 35) begin
        t = civil_day(y, 1, 1) * DAY_SECONDS;
      end else begin
        t = shift_instant(y, shift_e'($urandom_range(3)));
      end
      case ($urandom_range(9))
        3:       t -= 1;
        4:       t += 1;
        5, 6:    t += int'($urandom_range(7200)) - 3600;
        7, 8:    t += int'($urandom_range(345600)) - 172800;
        9:       t -= 3600;
        default: ;
      endcase
    end
    if (t < 0 || t > TIME_LIMIT) begin
      t = longint'($urandom());
    end
    return t[IN_W-1:0];
  endfunction

  task automatic send_request(logic [IN_W-1:0] t, int idle_pct);
    utc_seconds_i <= t;
    start         <= 1'b1;
    do @(posedge clk_i); while (busy);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0 && n < 200) begin
      @(posedge clk_i);
      n++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_zone(logic signed [OFF_W-1:0] off, logic [RULE_W-1:0] rule);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_STD_OFFSET;
    cfg_wdata_i <= off;
    @(posedge clk_i);
    cfg_idx_i   <= REG_DST_RULE;
    cfg_wdata_i <= {{(OFF_W-RULE_W){1'b0}}, rule};
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    zone_offset = off;
  endtask

  initial begin
    #2_000_000;
    $display("dst_local_offset_unit verification failed");
    $finish;
  end

  initial begin
    int                      idle_pct;
    logic signed [OFF_W-1:0] off;
    logic [RULE_W-1:0]       rule;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset zone: UTC, no daylight rule
    send_request('0, 0);
    send_request('1, 0);
    send_request(IN_W'(civil_day(2024, 2, 29) * DAY_SECONDS + 43200), 0);
    send_request(IN_W'(civil_day(2024, 1, 1) * DAY_SECONDS - 1), 0);
    send_request(IN_W'(civil_day(2024, 1, 1) * DAY_SECONDS), 0);
    wait_idle();

    set_zone(OFF_W'(-300), RULE_US);
    send_request(IN_W'(shift_instant(2024, US_SPRING) - 1), 0);
    send_request(IN_W'(shift_instant(2024, US_SPRING)), 0);
    send_request(IN_W'(shift_instant(2024, US_FALL) - 1), 0);
    send_request(IN_W'(shift_instant(2024, US_FALL)), 0);
    send_request(IN_W'(shift_instant(LAST_YEAR, US_FALL) - 1), 0);
    wait_idle();

    set_zone(OFF_W'(60), RULE_EU);
    send_request(IN_W'(shift_instant(2024, EU_SPRING) - 1), 0);
    send_request(IN_W'(shift_instant(2024, EU_SPRING)), 0);
    send_request(IN_W'(shift_instant(2024, EU_FALL) - 1), 0);
    send_request(IN_W'(shift_instant(2024, EU_FALL)), 0);
    send_request('1, 0);
    wait_idle();

    // saturate the daylight offset
    set_zone(OFF_W'(1000), RULE_US);
    send_request(IN_W'(civil_day(2024, 7, 1) * DAY_SECONDS), 0);
    send_request(IN_W'(shift_instant(2024, US_SPRING)), 0);
    wait_idle();

    set_zone(OFF_W'(-1024), RULE_US);
    send_request(IN_W'(shift_instant(2030, US_SPRING)), 0);
    send_request(IN_W'(shift_instant(2030, US_FALL) - 1), 0);
    wait_idle();

    set_zone(OFF_W'(1023), RULE_EU);
    send_request(IN_W'(civil_day(2024, 7, 1) * DAY_SECONDS), 0);
    wait_idle();

    set_zone(OFF_W'(-720), RULE_UNUSED);
    send_request(IN_W'(civil_day(2024, 7, 1) * DAY_SECONDS), 0);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin off = OFF_W'(-300);  rule = RULE_US;     end
        1: begin off = OFF_W'(60);    rule = RULE_EU;     end
        2: begin off = OFF_W'(0);     rule = RULE_NONE;   end
        3: begin off = OFF_W'(980);   rule = RULE_US;     end
        4: begin off = OFF_W'(-1024); rule = RULE_EU;     end
        5: begin off = OFF_W'(1023);  rule = RULE_US;     end
        6: begin off = OFF_W'(840);   rule = RULE_EU;     end
        7: begin off = OFF_W'(5);     rule = RULE_UNUSED; end
        default: begin
          off  = ($urandom_range(4) == 0) ? OFF_W'($urandom_range(2047))
                                          : OFF_W'(int'($urandom_range(1560)) - 720);
          rule = RULE_W'($urandom_range(3));
        end
      endcase
      set_zone(off, rule);
      idle_pct = (p < 4) ? 36 : ((p < 8) ? 46 : 0);
      repeat (PHASE_ITEMS) send_request(pick_utc(), idle_pct);
      wait_idle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("dst_local_offset_unit verification clean");
    end else begin
      $display("dst_local_offset_unit verification failed");
    end
    $finish;
  end

endmodule

### sim.f
design/dlo_pkg.sv
design/dlo_day_split.sv
design/dlo_year_find.sv
design/dlo_rule_eval.sv
design/dst_local_offset_unit.sv
tb/sv/dst_local_offset_unit_checker.sv
tb/sv/dst_local_offset_unit_tb.sv
